FILE: hdl/dq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int ITEM_WIDTH_DEF = 32;

    // Fixed field widths of the stream words
    localparam int FIELD_W = 32;
    localparam int COUNT_W = 5;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 104;

    typedef enum logic [1:0] {
        OP_QUERY      = 2'd0,
        OP_PUSH_RIGHT = 2'd1,
        OP_POP_LEFT   = 2'd2,
        OP_POP_RIGHT  = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic push;
        logic pop_left;
        logic pop_right;
    } cell_cmd_t;

endpackage

FILE: hdl/dq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_cell
// One slot of the queue chain. Slot 0 is the left end; valid slots form a
// contiguous run from slot 0. Pop left shifts the whole chain one slot down.
// ----------------------------------------------------------------------------
module dq_cell #(
    parameter int ITEM_WIDTH = dq_pkg::ITEM_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dq_pkg::cell_cmd_t     cmd,
    input  logic [ITEM_WIDTH-1:0] push_item,
    input  logic                  prev_valid,
    input  logic                  next_valid,
    input  logic [ITEM_WIDTH-1:0] next_data,
    output logic                  valid,
    output logic [ITEM_WIDTH-1:0] data,
    output logic [ITEM_WIDTH-1:0] tail_data
);
    import dq_pkg::*;

    logic                  valid_reg;
    logic                  valid_next;
    logic [ITEM_WIDTH-1:0] data_reg;
    logic [ITEM_WIDTH-1:0] data_next;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (cmd.pop_left)
        begin
            valid_next = next_valid;
            data_next  = next_data;
        end
        else if (cmd.pop_right)
        begin
            // the last valid slot is the one whose upper neighbor is empty
            valid_next = valid_reg & next_valid;
        end
        else if (cmd.push)
        begin
            // first empty slot takes the new word
            if (!valid_reg && prev_valid)
            begin
                valid_next = 1'b1;
                data_next  = push_item;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid     = valid_reg;
    assign data      = data_reg;
    assign tail_data = (valid_reg && !next_valid) ? data_reg : '0;

endmodule

FILE: hdl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque: push right, pop left, pop right, query, on a chain of slots.
// ----------------------------------------------------------------------------
//  Channel  Dir  Word fields (low bit up)
//  s_*      in   opcode[1:0], push_value[33:2], zero pad to 40 bits
//  m_*      out  popped_value, left_item, right_item, entry_count,
//                is_empty, status (104 bits)
//
//  Each word first updates the slot chain; in ST_GATHER both end items are
//  then collected into the output register. The right end is found by a
//  one-hot OR over the slots, shared by pop right and the result.
//  A new word is taken once the previous result has left or is leaving.
//  rst_n clears all slot valid bits and the count; no clearing pass.
//  m_tready low holds the result and blocks new input.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = dq_pkg::DEPTH_DEF,
    parameter int ITEM_WIDTH = dq_pkg::ITEM_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dq_pkg::S_DATA_W-1:0]   s_tdata,  // opcode, push_value, pad
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dq_pkg::M_DATA_W-1:0]   m_tdata   // popped, left, right,
                                                    // count, empty, status
);
    import dq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (ITEM_WIDTH < FIELD_W) ? ITEM_WIDTH : FIELD_W;

    typedef enum logic {
        ST_IDLE,
        ST_GATHER
    } state_t;

    state_t                state_reg;
    logic                  m_tvalid_reg;
    logic [M_DATA_W-1:0]   m_tdata_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [ITEM_WIDTH-1:0] popped_reg;
    logic [ITEM_WIDTH-1:0] popped_next;
    status_t               status_reg;
    status_t               status_next;

    logic                  in_accept;
    opcode_t               op;
    logic [ITEM_WIDTH-1:0] push_item;
    cell_cmd_t             cmd;

    logic [DEPTH-1:0]      cell_valid;
    logic [ITEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ITEM_WIDTH-1:0] cell_tail [DEPTH];
    logic [ITEM_WIDTH-1:0] right_item;
    logic [ITEM_WIDTH-1:0] left_item;

    logic [FIELD_W-1:0]    popped_w;
    logic [FIELD_W-1:0]    left_w;
    logic [FIELD_W-1:0]    right_w;

    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign in_accept = s_tvalid && s_tready;
    assign op        = opcode_t'(s_tdata[1:0]);
    assign push_item = ITEM_WIDTH'(s_tdata[2 +: CW]);

    // slot chain
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic                  prev_v;
            logic                  next_v;
            logic [ITEM_WIDTH-1:0] next_d;
            if (g == 0)
            begin : g_first
                assign prev_v = 1'b1;
            end
            else
            begin : g_mid
                assign prev_v = cell_valid[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign next_v = 1'b0;
                assign next_d = '0;
            end
            else
            begin : g_inner
                assign next_v = cell_valid[g+1];
                assign next_d = cell_data[g+1];
            end
            dq_cell #(
                .ITEM_WIDTH (ITEM_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .push_item  (push_item),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_data  (next_d),
                .valid      (cell_valid[g]),
                .data       (cell_data[g]),
                .tail_data  (cell_tail[g])
            );
        end
    endgenerate

    // at most one slot drives a nonzero tail
    always_comb
    begin
        right_item = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            right_item = right_item | cell_tail[i];
        end
    end

    assign left_item = cell_valid[0] ? cell_data[0] : '0;

    always_comb
    begin
        cmd         = '0;
        count_next  = count_reg;
        popped_next = '0;
        status_next = STATUS_OK;
        if (in_accept)
        begin
            unique case (op)
                OP_QUERY:
                begin
                end
                OP_PUSH_RIGHT:
                begin
                    if (count_reg == CNT_W'(DEPTH))
                    begin
                        status_next = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.push   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_LEFT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_left = 1'b1;
                        popped_next  = cell_data[0];
                        count_next   = count_reg - 1'b1;
                    end
                end
                OP_POP_RIGHT:
                begin
                    if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_right = 1'b1;
                        popped_next   = right_item;
                        count_next    = count_reg - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign popped_w = FIELD_W'(popped_reg[CW-1:0]);
    assign left_w   = FIELD_W'(left_item[CW-1:0]);
    assign right_w  = FIELD_W'(right_item[CW-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            count_reg    <= '0;
            popped_reg   <= '0;
            status_reg   <= STATUS_OK;
        end
        else
        begin
            count_reg <= count_next;
            if (in_accept)
            begin
                popped_reg <= popped_next;
                status_reg <= status_next;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (m_tready)
                    begin
                        m_tvalid_reg <= 1'b0;
                    end
                    if (in_accept)
                    begin
                        state_reg <= ST_GATHER;
                    end
                end
                ST_GATHER:
                begin
                    // previous word left at the accepting edge
                    m_tvalid_reg <= 1'b1;
                    m_tdata_reg  <= {status_reg, ~cell_valid[0], COUNT_W'(count_reg),
                                     right_w, left_w, popped_w};
                    state_reg    <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

FILE: hdl/dq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module dq_checker #(
    parameter int DEPTH = dq_pkg::DEPTH_DEF
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [dq_pkg::S_DATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [dq_pkg::M_DATA_W-1:0] m_tdata
);
    import dq_pkg::*;

    logic [FIELD_W-1:0] left_f;
    logic [FIELD_W-1:0] right_f;
    logic [COUNT_W-1:0] count_f;
    logic               empty_f;
    logic [1:0]         status_f;
    logic [1:0]         op_f;

    assign left_f   = m_tdata[63:32];
    assign right_f  = m_tdata[95:64];
    assign count_f  = m_tdata[100:96];
    assign empty_f  = m_tdata[101];
    assign status_f = m_tdata[103:102];
    assign op_f     = s_tdata[1:0];

    // stalled result word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // every accepted word is answered by a result word
    a_answer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result for accepted word");

    // empty queue shows zero ends and zero count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && empty_f |-> count_f == '0 && left_f == '0 && right_f == '0)
        else $error("empty result with nonzero fields");

    // a dropped push means the queue is full; an ignored pop means empty
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status_f != STATUS_FULL || count_f == COUNT_W'(DEPTH))
                  && (status_f != STATUS_EMPTY || empty_f))
        else $error("status disagrees with count");

    // a query never reports an error
    a_query: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && op_f == OP_QUERY |=> ##1 status_f == STATUS_OK)
        else $error("query reported an error");

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH (DEPTH)
) u_dq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

FILE: dv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the bounded deque: every accepted command word
// drives a local deque model, and each result word is checked field by
// field against the oldest prediction. Covers empty and full corner cases,
// pointer wrap, random traffic with both sides stalling, and a drain pause.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

    import dq_pkg::*;

    localparam int SLOTS = DEPTH_DEF;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_val;
        logic [FIELD_W-1:0] left_val;
        logic [FIELD_W-1:0] right_val;
        logic [COUNT_W-1:0] level;
        logic               none_left;
        status_t            status;
    } deque_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    // local copy of the deque
    logic [FIELD_W-1:0] model_store [SLOTS];
    logic [3:0]         model_left_ptr = '0;
    logic [COUNT_W-1:0] model_level = '0;

    deque_result_t pending_results [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatch_count = 0;
    int words_sent = 0;
    int words_checked = 0;
    int full_drops = 0;
    int empty_pops = 0;
    int peak_level = 0;

    double_ended_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("TIMEOUT: %0d results still outstanding", pending_results.size());
        $display("double_ended_queue test failed");
        $finish;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Apply one command to the model deque and return the result word it gives
    function automatic deque_result_t apply_deque_op(opcode_t op, logic [FIELD_W-1:0] val);
        deque_result_t res;
        logic [3:0]    idx;
        res = '0;
        res.status = STATUS_OK;
        case (op) inside
            OP_PUSH_RIGHT:
            begin
                if (model_level == COUNT_W'(SLOTS))
                    res.status = STATUS_FULL;
                else
                begin
                    idx = model_left_ptr + model_level[3:0];
                    model_store[idx] = val;
                    model_level = model_level + 1'b1;
                end
            end
            OP_POP_LEFT, OP_POP_RIGHT:
            begin
                if (model_level == '0)
                    res.status = STATUS_EMPTY;
                else if (op == OP_POP_LEFT)
                begin
                    res.popped_val = model_store[model_left_ptr];
                    model_left_ptr = model_left_ptr + 1'b1;
                    model_level = model_level - 1'b1;
                end
                else
                begin
                    idx = model_left_ptr + model_level[3:0] - 1'b1;
                    res.popped_val = model_store[idx];
                    model_level = model_level - 1'b1;
                end
            end
            default: ;
        endcase
        if (model_level != '0)
        begin
            idx = model_left_ptr + model_level[3:0] - 1'b1;
            res.left_val = model_store[model_left_ptr];
            res.right_val = model_store[idx];
        end
        res.level = model_level;
        res.none_left = (model_level == '0);
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [FIELD_W-1:0] got,
                                   input logic [FIELD_W-1:0] want);
        $display("%0t ns: MISMATCH %s got 0x%08h want 0x%08h (word %0d)",
                 $time, field, got, want, words_checked);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        deque_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected word", m_tdata[31:0], '0);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[31:0] !== want.popped_val)
                    report_mismatch("popped_value", m_tdata[31:0], want.popped_val);
                if (m_tdata[63:32] !== want.left_val)
                    report_mismatch("left_item", m_tdata[63:32], want.left_val);
                if (m_tdata[95:64] !== want.right_val)
                    report_mismatch("right_item", m_tdata[95:64], want.right_val);
                if (m_tdata[100:96] !== want.level)
                    report_mismatch("entry_count", FIELD_W'(m_tdata[100:96]),
                                    FIELD_W'(want.level));
                if (m_tdata[101] !== want.none_left)
                    report_mismatch("is_empty", FIELD_W'(m_tdata[101]),
                                    FIELD_W'(want.none_left));
                if (m_tdata[103:102] !== want.status)
                    report_mismatch("status", FIELD_W'(m_tdata[103:102]),
                                    FIELD_W'(want.status));
            end
            words_checked++;
        end
    end

    task automatic send_word(input opcode_t op, input logic [FIELD_W-1:0] val);
        deque_result_t res;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, op};
        do @(posedge clk); while (!s_tready);
        res = apply_deque_op(op, val);
        pending_results.insert(pending_results.size(), res);
        words_sent++;
        if (res.status == STATUS_FULL)
            full_drops++;
        if (res.status == STATUS_EMPTY)
            empty_pops++;
        if (int'(model_level) > peak_level)
            peak_level = int'(model_level);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_drain();
        int guard;
        guard = 0;
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_corner_cases();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(OP_QUERY, 32'h0);
        send_word(OP_POP_LEFT, 32'h0);
        send_word(OP_POP_RIGHT, 32'h0);
        send_word(OP_PUSH_RIGHT, 32'h0000_0000);
        send_word(OP_PUSH_RIGHT, 32'hFFFF_FFFF);
        send_word(OP_QUERY, 32'hFFFF_FFFF);   // push_value ignored on query
        send_word(OP_POP_RIGHT, 32'h0);
        send_word(OP_POP_LEFT, 32'h0);
        // fill to the top, then one push too many
        for (int i = 0; i < SLOTS; i++)
            send_word(OP_PUSH_RIGHT, (i % 2) ? 32'h5555_5555 ^ i : 32'hAAAA_AAAA ^ i);
        send_word(OP_PUSH_RIGHT, 32'hDEAD_BEEF);
        send_word(OP_POP_LEFT, 32'h0);
        send_word(OP_POP_RIGHT, 32'h0);
    endtask

    task automatic test_random_traffic(input int n_words, input int s_idle, input int r_idle);
        bit      grow;
        int      r;
        opcode_t op;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        grow = 1'b1;
        for (int i = 0; i < n_words; i++)
        begin
            if (model_level == COUNT_W'(SLOTS))
                grow = ($urandom_range(0, 3) == 0);
            else if (model_level == '0)
                grow = ($urandom_range(0, 3) != 0);
            else if ($urandom_range(0, 99) < 4)
                grow = !grow;
            r = $urandom_range(0, 99);
            if (r < (grow ? 60 : 20))
                op = OP_PUSH_RIGHT;
            else if (r < (grow ? 75 : 57))
                op = OP_POP_LEFT;
            else if (r < (grow ? 90 : 94))
                op = OP_POP_RIGHT;
            else
                op = OP_QUERY;
            send_word(op, pick_value());
        end
    endtask

    // Sender holds off completely mid-stream until the result side is clear
    task automatic test_drain_pause();
        send_idle_pct = 20;
        recv_idle_pct = 50;
        for (int i = 0; i < 10; i++)
            send_word(OP_PUSH_RIGHT, pick_value());
        wait_drain();
        for (int i = 0; i < 6; i++)
            send_word(($urandom_range(0, 1) != 0) ? OP_POP_LEFT : OP_POP_RIGHT, '0);
        wait_drain();
        send_word(OP_QUERY, pick_value());
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();
        test_random_traffic(210, 31, 81);
        test_random_traffic(210, 81, 31);
        test_drain_pause();
        test_random_traffic(210, 0, 0);

        wait_drain();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing words", FIELD_W'(pending_results.size()), '0);

        $display("Covered %0d command words, %0d results checked, peak occupancy %0d of %0d",
                 words_sent, words_checked, peak_level, SLOTS);
        $display("Pushes dropped on full: %0d, pops on empty: %0d, mismatches: %0d",
                 full_drops, empty_pops, mismatch_count);
        if (mismatch_count == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule
